// File: rtl/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants of the binary rANS encoder: microcode
// operations, the control word seen by the datapath and its status back.
// ----------------------------------------------------------------------------
package rbe_pkg;

    // coder state width and renormalisation lower bound
    localparam int STATE_W = 31;
    localparam logic [STATE_W-1:0] RANS_LOW = 31'd8388608;

    // default probability resolution
    localparam int PROB_BITS_DEF = 16;

    // configuration register
    localparam int FREQ_CFG_W = 16;
    localparam logic [FREQ_CFG_W-1:0] FREQ_ONE_RST = 16'd32768;

    // output byte
    localparam int BYTE_W = 8;

    // datapath operations driven by the microcode
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_RENORM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_EMIT,
        OP_CLEAR
    } op_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        op_t        op;
        logic [1:0] byte_sel;
        logic       last;
    } ctrl_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic is_flush;
        logic above;
        logic div_more;
        logic out_free;
    } status_t;

endpackage

// File: rtl/rbe_seq.sv
// ----------------------------------------------------------------------------
// rbe_seq
// Microcode sequencer: step counter, control ROM and jump conditions.
// Stalls on a byte emission while the output register is still occupied.
// ----------------------------------------------------------------------------
module rbe_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rbe_pkg::status_t status_i,
    output rbe_pkg::ctrl_t   ctrl_o
);

    typedef logic [3:0] step_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_FLUSH,
        COND_ABOVE,
        COND_DIV_MORE
    } cond_t;

    typedef struct packed {
        rbe_pkg::op_t op;
        cond_t        cond;
        step_t        target;
        logic [1:0]   byte_sel;
        logic         last;
    } uword_t;

    // program addresses
    localparam step_t STEP_WAIT     = 4'd0;
    localparam step_t STEP_DISPATCH = 4'd1;
    localparam step_t STEP_RENORM   = 4'd2;
    localparam step_t STEP_DIV_INIT = 4'd3;
    localparam step_t STEP_DIV      = 4'd4;
    localparam step_t STEP_UPDATE   = 4'd5;
    localparam step_t STEP_FLUSH_B3 = 4'd6;
    localparam step_t STEP_FLUSH_B2 = 4'd7;
    localparam step_t STEP_FLUSH_B1 = 4'd8;
    localparam step_t STEP_FLUSH_B0 = 4'd9;
    localparam step_t STEP_CLEAR    = 4'd10;

    // control store
    function automatic uword_t rom_word(input step_t a);
        uword_t w;
        w = '{op: rbe_pkg::OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT,
              byte_sel: 2'd0, last: 1'b0};
        unique case (a)
            STEP_WAIT:
            begin
                w.op     = rbe_pkg::OP_ACCEPT;
                w.cond   = COND_NO_INPUT;
                w.target = STEP_WAIT;
            end
            STEP_DISPATCH:
            begin
                w.cond   = COND_FLUSH;
                w.target = STEP_FLUSH_B3;
            end
            STEP_RENORM:
            begin
                w.op     = rbe_pkg::OP_RENORM;
                w.cond   = COND_ABOVE;
                w.target = STEP_RENORM;
            end
            STEP_DIV_INIT:
            begin
                w.op   = rbe_pkg::OP_DIV_INIT;
                w.cond = COND_NEVER;
            end
            STEP_DIV:
            begin
                w.op     = rbe_pkg::OP_DIV_STEP;
                w.cond   = COND_DIV_MORE;
                w.target = STEP_DIV;
            end
            STEP_UPDATE:
            begin
                w.op     = rbe_pkg::OP_UPDATE;
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            STEP_FLUSH_B3:
            begin
                w.op       = rbe_pkg::OP_EMIT;
                w.cond     = COND_NEVER;
                w.byte_sel = 2'd3;
            end
            STEP_FLUSH_B2:
            begin
                w.op       = rbe_pkg::OP_EMIT;
                w.cond     = COND_NEVER;
                w.byte_sel = 2'd2;
            end
            STEP_FLUSH_B1:
            begin
                w.op       = rbe_pkg::OP_EMIT;
                w.cond     = COND_NEVER;
                w.byte_sel = 2'd1;
            end
            STEP_FLUSH_B0:
            begin
                w.op       = rbe_pkg::OP_EMIT;
                w.cond     = COND_NEVER;
                w.byte_sel = 2'd0;
                w.last     = 1'b1;
            end
            STEP_CLEAR:
            begin
                w.op     = rbe_pkg::OP_CLEAR;
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    step_t  pc_reg;
    step_t  pc_next;
    uword_t word;
    logic   jump;
    logic   hold;

    assign word = rom_word(pc_reg);

    // jump condition
    always_comb
    begin
        unique case (word.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !in_valid;
            COND_FLUSH:    jump = status_i.is_flush;
            COND_ABOVE:    jump = status_i.above;
            COND_DIV_MORE: jump = status_i.div_more;
            default:       jump = 1'b0;
        endcase
    end

    // wait while a byte is due and the output register is full
    assign hold = !status_i.out_free &&
                  ((word.op == rbe_pkg::OP_EMIT) ||
                   ((word.op == rbe_pkg::OP_RENORM) && status_i.above));

    // next step
    always_comb
    begin
        priority if (hold)
            pc_next = pc_reg;
        else if (jump)
            pc_next = word.target;
        else
            pc_next = pc_reg + 4'd1;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT;
        else
            pc_reg <= pc_next;
    end

    // control word to the datapath
    assign ctrl_o.op       = hold ? rbe_pkg::OP_NOP : word.op;
    assign ctrl_o.byte_sel = word.byte_sel;
    assign ctrl_o.last     = word.last;

    // the program never runs past its final step
    assert property (@(posedge clk) disable iff (!rst_n) pc_reg <= STEP_CLEAR)
        else $error("step counter outside the program");

    // the final flush byte is followed by the state clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_o.op == rbe_pkg::OP_EMIT) && ctrl_o.last
        |=> (ctrl_o.op == rbe_pkg::OP_CLEAR))
        else $error("flush did not end with a state clear");

endmodule

// File: rtl/rbe_datapath.sv
// ----------------------------------------------------------------------------
// rbe_datapath
// Coder state, working register, shared restoring divider, renormalisation
// compare and the output register, all driven by the microcode word.
// ----------------------------------------------------------------------------
module rbe_datapath
#(
    parameter int PROB_BITS = rbe_pkg::PROB_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rbe_pkg::ctrl_t             ctrl_i,
    input  logic                       in_valid,
    input  logic                       operation,
    input  logic                       symbol,
    input  logic [PROB_BITS-1:0]       freq_eff,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [rbe_pkg::BYTE_W-1:0] out_byte,
    output logic                       last,
    output rbe_pkg::status_t           status_o
);

    localparam int SW         = rbe_pkg::STATE_W;
    localparam int BW         = rbe_pkg::BYTE_W;
    localparam int XMAX_SHIFT = SW - PROB_BITS;
    localparam int CNT_W      = $clog2(SW);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SW - 1);

    logic [SW-1:0]         state_reg, state_next;
    logic [SW-1:0]         x_reg, x_next;
    logic [PROB_BITS-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PROB_BITS-1:0]  freq_reg, freq_next;
    logic [PROB_BITS-1:0]  start_reg, start_next;
    logic                  flush_reg, flush_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BW-1:0]         out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    logic [PROB_BITS-1:0]  freq_neg;
    logic [SW-1:0]         x_max;
    logic [SW-1:0]         x_shr;
    logic                  above;
    logic                  renorm_last;
    logic [PROB_BITS:0]    trial;
    logic [PROB_BITS:0]    trial_diff;
    logic                  trial_ge;
    logic [SW:0]           flush_word;
    logic [BW-1:0]         flush_byte;
    logic [SW-1:0]         update_sum;
    logic                  emit;

    // frequency of symbol zero, also the start of symbol one
    assign freq_neg = '0 - freq_eff;

    // renormalisation bound and byte shift
    assign x_max       = SW'(freq_reg) << XMAX_SHIFT;
    assign x_shr       = x_reg >> BW;
    assign above       = x_reg >= x_max;
    assign renorm_last = x_shr < x_max;

    // one restoring division step, dividend shifted out of x_reg
    assign trial      = {rem_reg, x_reg[SW-1]};
    assign trial_diff = trial - {1'b0, freq_reg};
    assign trial_ge   = trial >= {1'b0, freq_reg};

    // flush byte select
    assign flush_word = {1'b0, x_reg};
    assign flush_byte = flush_word[{ctrl_i.byte_sel, 3'b000} +: BW];

    // new state from quotient, remainder and start
    assign update_sum = (x_reg << PROB_BITS) + SW'(rem_reg) + SW'(start_reg);

    // datapath operation
    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        freq_next     = freq_reg;
        start_next    = start_reg;
        flush_next    = flush_reg;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        unique case (ctrl_i.op)
            rbe_pkg::OP_NOP:
            begin
            end
            rbe_pkg::OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    x_next     = state_reg;
                    flush_next = operation;
                    freq_next  = symbol ? freq_eff : freq_neg;
                    start_next = symbol ? freq_neg : '0;
                end
            end
            rbe_pkg::OP_RENORM:
            begin
                if (above)
                begin
                    emit          = 1'b1;
                    out_byte_next = x_reg[BW-1:0];
                    out_last_next = renorm_last;
                    x_next        = x_shr;
                end
            end
            rbe_pkg::OP_DIV_INIT:
            begin
                rem_next = '0;
                cnt_next = '0;
            end
            rbe_pkg::OP_DIV_STEP:
            begin
                rem_next = trial_ge ? trial_diff[PROB_BITS-1:0] : trial[PROB_BITS-1:0];
                x_next   = {x_reg[SW-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            rbe_pkg::OP_UPDATE:
            begin
                state_next = update_sum;
            end
            rbe_pkg::OP_EMIT:
            begin
                emit          = 1'b1;
                out_byte_next = flush_byte;
                out_last_next = ctrl_i.last;
            end
            rbe_pkg::OP_CLEAR:
            begin
                state_next = rbe_pkg::RANS_LOW;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        priority if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbe_pkg::RANS_LOW;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        freq_reg     <= freq_next;
        start_reg    <= start_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

    assign status_o.is_flush = flush_reg;
    assign status_o.above    = above;
    assign status_o.div_more = cnt_reg != DIV_LAST;
    assign status_o.out_free = !out_valid_reg || out_ready;

    // the coder state never drops below the lower bound
    assert property (@(posedge clk) disable iff (!rst_n) state_reg >= rbe_pkg::RANS_LOW)
        else $error("coder state below lower bound");

    // the divider leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_i.op == rbe_pkg::OP_UPDATE) |-> (rem_reg < freq_reg))
        else $error("division remainder out of range");

endmodule

// File: rtl/rans_binary_encoder.sv
// ----------------------------------------------------------------------------
// rans_binary_encoder
// Byte-wise rANS encoder for a binary alphabet with a static quantised
// probability, run by a microcoded sequencer over a shared divider datapath.
// ----------------------------------------------------------------------------
// Encode transaction: from acceptance to the next free input slot it runs
//   dispatch, renormalisation (0 to 2 bytes), divider set-up, the 31-step
//   divider and the update; a renormalisation byte waits on out_ready.
// Flush transaction: four bytes then a state clear, waiting on out_ready.
// A byte is shown the cycle after it is produced, from the output register.
// Reset: state to the lower bound, freq_one to 32768, output empty.
// ----------------------------------------------------------------------------
module rans_binary_encoder
#(
    parameter int PROB_BITS = rbe_pkg::PROB_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rbe_pkg::FREQ_CFG_W-1:0] freq_one,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic                           symbol,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rbe_pkg::BYTE_W-1:0]     out_byte,
    output logic                           last
);

    localparam int FW = rbe_pkg::FREQ_CFG_W;
    localparam logic [FW:0] FREQ_MAX = (FW+1)'((1 << PROB_BITS) - 1);

    logic [FW-1:0]         freq_one_reg;
    logic [PROB_BITS-1:0]  freq_eff;
    rbe_pkg::ctrl_t        ctrl;
    rbe_pkg::status_t      status;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            freq_one_reg <= rbe_pkg::FREQ_ONE_RST;
        else if (cfg_valid)
            freq_one_reg <= freq_one;
    end

    // raise a zero frequency to one, saturate it to one below the scale
    always_comb
    begin
        priority if (freq_one_reg == '0)
            freq_eff = PROB_BITS'(1);
        else if ({1'b0, freq_one_reg} > FREQ_MAX)
            freq_eff = FREQ_MAX[PROB_BITS-1:0];
        else
            freq_eff = freq_one_reg[PROB_BITS-1:0];
    end

    // input taken only on the wait step
    assign in_ready = ctrl.op == rbe_pkg::OP_ACCEPT;

    rbe_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status_i (status),
        .ctrl_o   (ctrl)
    );

    rbe_datapath
    #(
        .PROB_BITS (PROB_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_i    (ctrl),
        .in_valid  (in_valid),
        .operation (operation),
        .symbol    (symbol),
        .freq_eff  (freq_eff),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last),
        .status_o  (status)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary rANS encoder. A predictor holds its own
// coder state and frequency setting, works out the byte stream each symbol or
// flush transaction should produce, and a monitor compares every output byte
// with the oldest predicted one. Directed cases cover the frequency extremes
// and flushes, then random symbol streams run under several settings, most of
// them with random input gaps, random output stalls or both.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PROB_BITS = rbe_pkg::PROB_BITS_DEF;
    localparam int PERIOD_NS = 12;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT = 40000;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    // operation field codes
    localparam logic ENC_SYMBOL = 1'b0;
    localparam logic ENC_FLUSH = 1'b1;

    // idling styles for either side
    typedef enum int { IDLE_NONE, IDLE_RANDOM } idle_mode_t;

    typedef struct packed {
        logic [rbe_pkg::BYTE_W-1:0] data;
        logic                       last;
    } coded_byte_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rbe_pkg::FREQ_CFG_W-1:0] freq_one = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           operation = 1'b0;
    logic                           symbol = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [rbe_pkg::BYTE_W-1:0]     out_byte;
    logic                           last;

    // predictor state
    logic [rbe_pkg::STATE_W-1:0]    coder_x = rbe_pkg::RANS_LOW;
    logic [rbe_pkg::FREQ_CFG_W-1:0] freq_one_cfg = rbe_pkg::FREQ_ONE_RST;
    coded_byte_t                    pending_bytes[$];

    idle_mode_t tx_mode = IDLE_NONE;
    idle_mode_t rx_mode = IDLE_NONE;
    int         rx_stall_left = 0;
    int         error_count = 0;

    rans_binary_encoder #(.PROB_BITS(PROB_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .freq_one  (freq_one),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .symbol    (symbol),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    always #(PERIOD_NS / 2) clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // expected bytes of one accepted transaction, predictor state advanced
    task automatic predict_bytes(logic op, logic sym);
        logic [16:0]  scale_m;
        logic [16:0]  f1;
        logic [16:0]  freq;
        logic [16:0]  start;
        logic [63:0]  x;
        logic [63:0]  x_max;
        logic [63:0]  q;
        logic [63:0]  r;
        logic [31:0]  s;
        coded_byte_t  emitted[4];
        int           n;
        n = 0;
        if (op == ENC_FLUSH) begin
            s = {1'b0, coder_x};
            for (int k = 0; k < 4; k++) begin
                emitted[k].data = s[31 - 8*k -: 8];
                emitted[k].last = (k == 3);
            end
            n = 4;
            coder_x = rbe_pkg::RANS_LOW;
        end
        else begin
            // saturate the setting into [1, M - 1]
            scale_m = 17'd1 << PROB_BITS;
            f1 = {1'b0, freq_one_cfg};
            if (f1 < 17'd1)
                f1 = 17'd1;
            if (f1 > scale_m - 17'd1)
                f1 = scale_m - 17'd1;
            freq = sym ? f1 : scale_m - f1;
            start = sym ? scale_m - f1 : 17'd0;
            x = 64'(coder_x);
            x_max = ((64'(rbe_pkg::RANS_LOW) >> PROB_BITS) << 8) * 64'(freq);
            // renormalise: shed low bytes while the state is too large
            while (x >= x_max && n < 4) begin
                emitted[n].data = x[7:0];
                emitted[n].last = 1'b0;
                n++;
                x = x >> 8;
            end
            if (n > 0)
                emitted[n-1].last = 1'b1;
            q = x / 64'(freq);
            r = x % 64'(freq);
            coder_x = rbe_pkg::STATE_W'((q << PROB_BITS) + r + 64'(start));
        end
        for (int k = 0; k < n; k++)
            pending_bytes.push_back(emitted[k]);
    endtask

    // one input transaction; starts and ends just after a falling edge
    task automatic send_item(logic op, logic sym);
        int gap;
        gap = (tx_mode == IDLE_RANDOM) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = op;
        symbol = sym;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_bytes(op, sym);
        @(negedge clk);
    endtask

    task automatic stop_input();
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_input();
        while (pending_bytes.size() != 0)
            @(negedge clk);
    endtask

    // register write, only with the encoder idle
    task automatic write_freq_one(logic [rbe_pkg::FREQ_CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        freq_one = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        freq_one_cfg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // output side stalls
    always @(negedge clk) begin
        if (rx_mode == IDLE_NONE) begin
            out_ready <= 1'b1;
        end
        else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            rx_stall_left = pick_gap();
            out_ready <= (rx_stall_left == 0);
            if (rx_stall_left > 0)
                rx_stall_left = rx_stall_left - 1;
        end
    end

    // compare each output transaction with the oldest predicted byte
    always @(posedge clk) begin
        coded_byte_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected out_byte", int'(out_byte), 0);
            end
            else begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", int'(out_byte), int'(want.data));
                if (last !== want.last)
                    report_mismatch("last", int'(last), int'(want.last));
            end
        end
    end

    // reset setting: flushes of the initial state, both symbols
    task automatic test_reset_setting();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        send_item(ENC_FLUSH, 1'b0);
        send_item(ENC_SYMBOL, 1'b0);
        send_item(ENC_SYMBOL, 1'b1);
        send_item(ENC_FLUSH, 1'b1);
        send_item(ENC_SYMBOL, 1'b1);
        send_item(ENC_SYMBOL, 1'b1);
        send_item(ENC_FLUSH, 1'b0);
        stop_input();
    endtask

    // frequency extremes, zero saturates to one, full scale to M - 1
    task automatic test_freq_extremes();
        write_freq_one(16'd0);
        repeat (4) send_item(ENC_SYMBOL, 1'b1);
        send_item(ENC_SYMBOL, 1'b0);
        send_item(ENC_FLUSH, 1'b1);
        write_freq_one(16'hffff);
        repeat (4) send_item(ENC_SYMBOL, 1'b0);
        send_item(ENC_SYMBOL, 1'b1);
        send_item(ENC_FLUSH, 1'b0);
        write_freq_one(16'd1);
        repeat (2) send_item(ENC_SYMBOL, 1'b1);
        send_item(ENC_FLUSH, 1'b1);
        stop_input();
    endtask

    // random streams ending in flushes, symbols mostly follow the setting
    task automatic test_random_stream(logic [rbe_pkg::FREQ_CFG_W-1:0] setting,
                                      idle_mode_t tx, idle_mode_t rx, int count);
        int  r;
        logic op;
        logic sym;
        write_freq_one(setting);
        tx_mode = tx;
        rx_mode = rx;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            op = (r < 12) ? ENC_FLUSH : ENC_SYMBOL;
            if ($urandom_range(0, 4) != 0)
                sym = ($urandom_range(0, 65535) < 32'(setting));
            else
                sym = 1'($urandom_range(0, 1));
            send_item(op, sym);
            // hold off once per stream until the output side has caught up
            if (i == count / 2)
                wait_drained();
        end
        send_item(ENC_FLUSH, 1'($urandom_range(0, 1)));
        stop_input();
    endtask

    initial begin
        int waited;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_setting();
        test_freq_extremes();
        test_random_stream(16'h8000, IDLE_NONE, IDLE_NONE, 44);
        test_random_stream(16'($urandom_range(1, 300)), IDLE_RANDOM, IDLE_RANDOM, 44);
        test_random_stream(16'($urandom_range(65200, 65535)), IDLE_RANDOM, IDLE_RANDOM, 44);
        test_random_stream(16'd2, IDLE_NONE, IDLE_RANDOM, 44);
        test_random_stream(16'hfffe, IDLE_RANDOM, IDLE_NONE, 44);
        test_random_stream(16'($urandom()), IDLE_RANDOM, IDLE_RANDOM, 44);

        // wait for the last bytes, then a quiet spell for stray output
        stop_input();
        waited = 0;
        while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_bytes.size() != 0)
            report_mismatch("bytes never produced", 0, pending_bytes.size());
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // overall run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
